[rtl/core/fpws_pkg.sv]
`default_nettype none
package fpws_pkg;

  localparam int ADDR_W = 24;
  localparam int CNT_W  = 14;
  localparam int LEN_W  = 11;
  localparam int STEP_W = 5;

  localparam logic [CNT_W-1:0] MAX_REQUEST = 14'd8192;
  localparam logic [LEN_W-1:0] MAX_PAGE    = 11'd1024;
  localparam logic [LEN_W-1:0] MIN_PAGE    = 11'd256;
  localparam logic [LEN_W-1:0] PAGE_RESET  = 11'd512;

  localparam logic [STEP_W-1:0] STEP_TOP = STEP_W'(ADDR_W - 1);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_DIV,
    FS_PUSH
  } fpws_front_state_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [CNT_W-1:0]  count;
    logic [LEN_W-1:0]  first_len;
    logic [LEN_W-1:0]  ps;
    logic              err;
  } fpws_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fpws_qstat_t;

endpackage
`default_nettype wire

[rtl/core/fpws_if.sv]
`default_nettype none
interface fpws_req_if;
  logic                      valid;
  logic                      ready;
  logic [fpws_pkg::ADDR_W-1:0] start_address;
  logic [fpws_pkg::CNT_W-1:0]  byte_count;

  modport source(output valid, output start_address, output byte_count, input ready);
  modport sink(input valid, input start_address, input byte_count, output ready);
endinterface

interface fpws_chunk_if;
  logic                      valid;
  logic                      ready;
  logic [fpws_pkg::ADDR_W-1:0] chunk_address;
  logic [fpws_pkg::LEN_W-1:0]  chunk_length;
  logic                      last_chunk;
  logic                      error;

  modport source(output valid, output chunk_address, output chunk_length,
                 output last_chunk, output error, input ready);
  modport sink(input valid, input chunk_address, input chunk_length,
               input last_chunk, input error, output ready);
endinterface
`default_nettype wire

[rtl/core/fpws_front.sv]
`default_nettype none
module fpws_front (
  input  wire logic                      clk,
  input  wire logic                      rst,
  fpws_req_if.sink                       req,
  input  wire logic [fpws_pkg::LEN_W-1:0] page_size,
  input  wire fpws_pkg::fpws_qstat_t     qstat,
  output fpws_pkg::fpws_cmd_t            cmd,
  output logic                           push
);

  fpws_pkg::fpws_front_state_t state, state_next;

  logic [fpws_pkg::ADDR_W-1:0] addr;
  logic [fpws_pkg::CNT_W-1:0]  count;
  logic [fpws_pkg::LEN_W-1:0]  ps;
  logic [fpws_pkg::LEN_W-1:0]  rem;
  logic [fpws_pkg::STEP_W-1:0] step;
  logic                        err;
  logic                        special;

  logic [fpws_pkg::LEN_W-1:0]  ps_eff;
  logic [fpws_pkg::LEN_W:0]    shifted;
  logic [fpws_pkg::LEN_W-1:0]  rem_next;
  logic [fpws_pkg::LEN_W-1:0]  to_page_end;
  logic                        accept;

  always_comb begin
    ps_eff = page_size;
    if (page_size < fpws_pkg::MIN_PAGE) ps_eff = fpws_pkg::MIN_PAGE;
    if (page_size > fpws_pkg::MAX_PAGE) ps_eff = fpws_pkg::MAX_PAGE;
  end

  assign accept  = req.valid && req.ready;
  assign shifted = {rem, addr[step]};

  always_comb begin
    if (shifted >= {1'b0, ps}) begin
      rem_next = fpws_pkg::LEN_W'(shifted - {1'b0, ps});
    end else begin
      rem_next = shifted[fpws_pkg::LEN_W-1:0];
    end
  end

  assign to_page_end = ps - rem;

  always_comb begin
    cmd.addr  = addr;
    cmd.count = count;
    cmd.ps    = ps;
    cmd.err   = err;
    if (special) begin
      cmd.first_len = '0;
    end else if (count < {3'b000, to_page_end}) begin
      cmd.first_len = count[fpws_pkg::LEN_W-1:0];
    end else begin
      cmd.first_len = to_page_end;
    end
  end

  always_comb begin
    state_next = state;
    req.ready  = 1'b0;
    push       = 1'b0;
    unique case (state)
      fpws_pkg::FS_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          if (req.byte_count > fpws_pkg::MAX_REQUEST || req.byte_count == '0) begin
            state_next = fpws_pkg::FS_PUSH;
          end else begin
            state_next = fpws_pkg::FS_DIV;
          end
        end
      end
      fpws_pkg::FS_DIV: begin
        if (step == '0) state_next = fpws_pkg::FS_PUSH;
      end
      fpws_pkg::FS_PUSH: begin
        push = !qstat.full;
        if (!qstat.full) state_next = fpws_pkg::FS_IDLE;
      end
      default: state_next = fpws_pkg::FS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fpws_pkg::FS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      addr    <= req.start_address;
      count   <= req.byte_count;
      ps      <= ps_eff;
      rem     <= '0;
      step    <= fpws_pkg::STEP_TOP;
      err     <= req.byte_count > fpws_pkg::MAX_REQUEST;
      special <= req.byte_count > fpws_pkg::MAX_REQUEST || req.byte_count == '0;
    end else if (state == fpws_pkg::FS_DIV) begin
      rem  <= rem_next;
      step <= step - 1'b1;
    end
  end

endmodule
`default_nettype wire

[rtl/core/fpws_queue.sv]
`default_nettype none
module fpws_queue (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire fpws_pkg::fpws_cmd_t   wr_cmd,
  input  wire logic                  pop,
  output fpws_pkg::fpws_cmd_t        rd_cmd,
  output fpws_pkg::fpws_qstat_t      qstat
);

  fpws_pkg::fpws_cmd_t mem [fpws_pkg::QUEUE_DEPTH];

  logic [fpws_pkg::QPTR_W-1:0] wr_ptr;
  logic [fpws_pkg::QPTR_W-1:0] rd_ptr;
  logic [fpws_pkg::QCNT_W-1:0] fill;

  assign qstat.full  = fill == fpws_pkg::QCNT_W'(fpws_pkg::QUEUE_DEPTH);
  assign qstat.empty = fill == '0;
  assign rd_cmd      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) fill <= fill + 1'b1;
      else if (pop && !push) fill <= fill - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wr_cmd;
  end

endmodule
`default_nettype wire

[rtl/core/fpws_back.sv]
`default_nettype none
module fpws_back (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire fpws_pkg::fpws_cmd_t   cmd,
  input  wire fpws_pkg::fpws_qstat_t qstat,
  output logic                       pop,
  fpws_chunk_if.source               chunk
);

  logic                        out_valid;
  logic [fpws_pkg::ADDR_W-1:0] out_addr;
  logic [fpws_pkg::LEN_W-1:0]  out_len;
  logic                        out_last;
  logic                        out_err;
  logic [fpws_pkg::CNT_W-1:0]  rem_bytes;
  logic [fpws_pkg::ADDR_W-1:0] nxt_addr;
  logic [fpws_pkg::LEN_W-1:0]  ps;

  logic                        taken;
  logic                        adv;
  logic [fpws_pkg::LEN_W-1:0]  len_next;
  logic                        rem_small;

  assign chunk.valid         = out_valid;
  assign chunk.chunk_address = out_addr;
  assign chunk.chunk_length  = out_len;
  assign chunk.last_chunk    = out_last;
  assign chunk.error         = out_err;

  assign taken     = out_valid && chunk.ready;
  assign pop       = !qstat.empty && (!out_valid || (taken && out_last));
  assign adv       = taken && !out_last;
  assign rem_small = rem_bytes <= {3'b000, ps};
  assign len_next  = rem_small ? rem_bytes[fpws_pkg::LEN_W-1:0] : ps;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (taken && out_last) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_addr  <= cmd.addr;
      out_len   <= cmd.first_len;
      out_last  <= cmd.err || cmd.count == {3'b000, cmd.first_len};
      out_err   <= cmd.err;
      rem_bytes <= cmd.count - {3'b000, cmd.first_len};
      nxt_addr  <= cmd.addr + {13'd0, cmd.first_len};
      ps        <= cmd.ps;
    end else if (adv) begin
      out_addr  <= nxt_addr;
      out_len   <= len_next;
      out_last  <= rem_small;
      rem_bytes <= rem_bytes - {3'b000, len_next};
      nxt_addr  <= nxt_addr + {13'd0, len_next};
    end
  end

  a_err_single : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_err |-> out_last && out_len == '0)
    else $error("error word not a single empty last word");

  a_len_page : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_len <= ps)
    else $error("chunk longer than page");

  a_more_left : assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_last |-> rem_bytes != '0)
    else $error("non-last chunk with nothing left");

  a_addr_chain : assert property (@(posedge clk) disable iff (rst)
    taken && !out_last |=> out_valid &&
      out_addr == $past(out_addr) + {13'd0, $past(out_len)})
    else $error("chunk address does not follow previous chunk");

endmodule
`default_nettype wire

[rtl/core/flash_page_write_splitter_unit.sv]
`default_nettype none
// channel  dir  fields                                                   handshake
// req      in   start_address[23:0] byte_count[13:0]                     valid/ready
// chunk    out  chunk_address[23:0] chunk_length[10:0] last_chunk error  valid/ready
// cfg      in   cfg_wdata[10:0] (page_size)                              cfg_we
//
// Front: accept, then page-offset remainder (one address bit per cycle, bit 23
// down to bit 0), then queue push; empty and oversized requests skip the remainder.
// Back: one chunk word per cycle while chunk.ready is high and, between requests, the queue is not empty.
// The front takes no new request until the last is pushed; the back may still be emitting earlier chunks.
// Reset clears the FSM, queue and output valid; page_size returns to 512.
// A stalled chunk channel fills the two-entry queue, then holds req.ready low.
module flash_page_write_splitter_unit (
  input  wire logic                       clk,
  input  wire logic                       rst,
  fpws_req_if.sink                        req,
  fpws_chunk_if.source                    chunk,
  input  wire logic                       cfg_we,
  input  wire logic [fpws_pkg::LEN_W-1:0] cfg_wdata
);

  logic [fpws_pkg::LEN_W-1:0] page_size;

  fpws_pkg::fpws_cmd_t   wr_cmd;
  fpws_pkg::fpws_cmd_t   rd_cmd;
  fpws_pkg::fpws_qstat_t qstat;
  logic                  push;
  logic                  pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      page_size <= fpws_pkg::PAGE_RESET;
    end else if (cfg_we) begin
      page_size <= cfg_wdata;
    end
  end

  fpws_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .page_size (page_size),
    .qstat     (qstat),
    .cmd       (wr_cmd),
    .push      (push)
  );

  fpws_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_cmd (wr_cmd),
    .pop    (pop),
    .rd_cmd (rd_cmd),
    .qstat  (qstat)
  );

  fpws_back u_back (
    .clk   (clk),
    .rst   (rst),
    .cmd   (rd_cmd),
    .qstat (qstat),
    .pop   (pop),
    .chunk (chunk)
  );

endmodule
`default_nettype wire
